FILE: sv/wdt_pkg.sv
// Shared types and constants for the word deduplication table.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package wdt_pkg;

    localparam logic [7:0] SPACE_CODE = 8'd32;

    // Controller to datapath
    typedef struct packed {
        logic append;   // buffer the accepted byte
        logic start;    // word finished, arm the table search
        logic search;   // one table row read and compared per cycle
        logic commit;   // insert if unseen and the table is not full, load the result, clear the token
    } wdt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_break;    // presented item finishes a word
        logic count_zero;  // table empty
        logic hit;         // compared row matches the token
        logic last;        // compared row is the last stored one
        logic out_free;    // result register can take a new result
    } wdt_sts_t;

endpackage

`default_nettype wire

FILE: sv/wdt_in_if.sv
// Input channel: one text byte or one line-end mark per transfer.
// No dependencies.
`default_nettype none

interface wdt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_line;

    modport source (output valid, output char_code, output end_of_line, input ready);
    modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

`default_nettype wire

FILE: sv/wdt_out_if.sv
// Result channel: one lookup result per finished word.
// No dependencies.
`default_nettype none

interface wdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] word_index;
    logic       is_new;
    logic       table_full;
    logic       too_long;

    modport source (output valid, output word_index, output is_new, output table_full,
                    output too_long, input ready);
    modport sink   (input valid, input word_index, input is_new, input table_full,
                    input too_long, output ready);
endinterface

`default_nettype wire

FILE: sv/wdt_ctrl.sv
// Controller state machine for the word deduplication table.
// Depends on wdt_pkg (command and status types).
`default_nettype none

module wdt_ctrl
    import wdt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire wdt_sts_t sts,
    output wdt_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_break)
                    begin
                        cmd.start  = 1'b1;
                        state_next = sts.count_zero ? ST_COMMIT : ST_SEARCH;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.hit || sts.last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wdt_datapath.sv
// Datapath of the word deduplication table: token buffer, word table memory
// (one row per word, bytes and length), row compare and result register.
// Depends on wdt_pkg (command and status types, space code).
`default_nettype none

module wdt_datapath
    import wdt_pkg::*;
#(
    parameter int MAX_WORDS = 256,
    parameter int MAX_LEN   = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic [7:0] char_code,
    input  wire logic     end_of_line,
    input  wire logic     out_ready,
    input  wire wdt_cmd_t cmd,
    output wdt_sts_t      sts,
    output logic          out_valid,
    output logic [7:0]    word_index,
    output logic          is_new,
    output logic          table_full,
    output logic          too_long
);

    localparam int IW = $clog2(MAX_WORDS);
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int BW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = MAX_LEN * 8;
    localparam int RW = DW + LW;

    // token
    logic [7:0]    tok_reg [MAX_LEN];
    logic [LW-1:0] tok_len_reg;
    logic [LW-1:0] tok_len_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [DW-1:0] tok_flat;

    // table
    logic [RW-1:0] mem [MAX_WORDS];
    logic [RW-1:0] rd_row_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rd_addr_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          cmp_valid_reg;
    logic          found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          rd_en;
    logic          wr_en;
    logic          full;

    // compare
    logic [MAX_LEN-1:0] lane_ok;
    logic               match;

    // result register
    logic       out_valid_reg;
    logic [7:0] word_index_reg;
    logic       is_new_reg;
    logic       table_full_reg;
    logic       too_long_reg;

    assign full  = (cnt_reg == CW'(MAX_WORDS));
    assign rd_en = cmd.search && (rd_addr_reg < cnt_reg);
    assign wr_en = cmd.commit && !found_reg && !full;

    always_comb
    begin
        for (int k = 0; k < MAX_LEN; k++)
        begin
            tok_flat[k*8 +: 8] = tok_reg[k];
            lane_ok[k] = (LW'(k) >= tok_len_reg) || (rd_row_reg[k*8 +: 8] == tok_reg[k]);
        end
    end

    assign match = (rd_row_reg[RW-1:DW] == tok_len_reg) && (&lane_ok);

    assign sts.is_break   = end_of_line || (char_code == SPACE_CODE);
    assign sts.count_zero = (cnt_reg == '0);
    assign sts.hit        = cmp_valid_reg && match;
    assign sts.last       = cmp_valid_reg && ((CW'(cmp_idx_reg) + CW'(1)) == cnt_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        tok_len_next = tok_len_reg;
        ovf_next     = ovf_reg;
        if (cmd.commit)
        begin
            tok_len_next = '0;
            ovf_next     = 1'b0;
        end
        else if (cmd.append)
        begin
            if (tok_len_reg < LW'(MAX_LEN))
            begin
                tok_len_next = tok_len_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && (tok_len_reg < LW'(MAX_LEN)))
        begin
            tok_reg[tok_len_reg[BW-1:0]] <= char_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[IW-1:0]] <= {tok_len_reg, tok_flat};
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cmp_idx_reg <= rd_addr_reg[IW-1:0];
        end
        if (cmd.search && sts.hit)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        if (cmd.commit)
        begin
            word_index_reg <= found_reg ? 8'(hit_idx_reg) : (full ? 8'd0 : 8'(cnt_reg));
            is_new_reg     <= !found_reg && !full;
            table_full_reg <= !found_reg && full;
            too_long_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tok_len_reg   <= tok_len_next;
            ovf_reg       <= ovf_next;
            cmp_valid_reg <= rd_en;
            if (wr_en)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.start)
            begin
                rd_addr_reg <= '0;
                found_reg   <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    rd_addr_reg <= rd_addr_reg + CW'(1);
                end
                if (cmd.search && sts.hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign word_index = word_index_reg;
    assign is_new     = is_new_reg;
    assign table_full = table_full_reg;
    assign too_long   = too_long_reg;

endmodule

`default_nettype wire

FILE: sv/word_dedup_table.sv
// Word deduplication table: top level joining controller and datapath.
// Depends on wdt_pkg, wdt_in_if, wdt_out_if, wdt_ctrl and wdt_datapath.
//
// Usage:
//   chars   : one transfer per text byte, or a line-end mark (end_of_line = 1,
//             char_code ignored). A space or a line end finishes the current word.
//   results : one transfer per finished word: word_index, is_new, table_full,
//             too_long. Ordinary bytes produce no result.
//   Lookup  : a finished word searches the N stored words (N at most MAX_WORDS),
//             one row per cycle from the word memory, compared in full against
//             the token, until a match or the last stored row. Its result is
//             then loaded into the output register once that register is free;
//             on an empty table the search is skipped.
//   One word is looked up at a time; chars is not ready during a search.
//   The result register parts both sides: bytes of the next word are taken
//   while a result waits. A stalled receiver holds the next word's commit
//   until the register frees.
//   Reset empties the table and the token buffer at once; no clearing pass.
//   Only rows below the word count are ever read.
`default_nettype none

module word_dedup_table
    import wdt_pkg::*;
#(
    parameter int MAX_WORDS = 256,
    parameter int MAX_LEN   = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    wdt_in_if.sink     chars,
    wdt_out_if.source  results
);

    wdt_cmd_t cmd;
    wdt_sts_t sts;

    wdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wdt_datapath #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (chars.char_code),
        .end_of_line (chars.end_of_line),
        .out_ready   (results.ready),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (results.valid),
        .word_index  (results.word_index),
        .is_new      (results.is_new),
        .table_full  (results.table_full),
        .too_long    (results.too_long)
    );

    a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !chars.ready)
        else $error("input taken during a word lookup");

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> results.valid)
        else $error("committed word gave no result");

    a_new_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !(results.is_new && results.table_full))
        else $error("result both inserted and dropped");

    a_full_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.table_full) |-> (results.word_index == 8'd0))
        else $error("dropped word with nonzero index");

endmodule

`default_nettype wire
